// File: rtl/ps2kmc_pkg.sv
package ps2kmc_pkg;

    typedef enum logic [2:0] {
        OP_RD_STATUS = 3'd0,
        OP_RD_DATA   = 3'd1,
        OP_WR_CMD    = 3'd2,
        OP_WR_DATA   = 3'd3,
        OP_KEY       = 3'd4,
        OP_POINTER   = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data_byte;
        logic [15:0] key_sym;
        logic        key_down;
        logic [2:0]  buttons;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } req_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       irq_kbd;
        logic       irq_aux;
    } rsp_t;

    // Up to four bytes queued per request, on one of the two rings.
    typedef struct packed {
        logic       to_aux;
        logic [2:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } push_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ,
        ST_DONE
    } state_t;

    localparam logic [7:0] STAT_BASE   = 8'h1c;
    localparam logic [7:0] ACK_BYTE    = 8'hfa;
    localparam logic [7:0] BAT_OK      = 8'hab;
    localparam logic [7:0] KBD_ID      = 8'h41;
    localparam logic [7:0] EXT_PREFIX  = 8'he0;
    localparam logic [7:0] BRK_PREFIX  = 8'hf0;
    localparam logic [7:0] MODE_RESET  = 8'h03;
    localparam logic [7:0] MODE_AUX_OFF = 8'h20;
    localparam logic [7:0] MS_SCALING  = 8'h10;
    localparam logic [7:0] MS_REPORT   = 8'h20;
    localparam logic [7:0] MS_DEF_RES  = 8'd2;
    localparam logic [7:0] MS_DEF_RATE = 8'd100;

    localparam logic [7:0] CMD_RD_MODE  = 8'h20;
    localparam logic [7:0] CMD_WR_MODE  = 8'h60;
    localparam logic [7:0] CMD_AUX_LOOP = 8'hd3;
    localparam logic [7:0] CMD_AUX_SEND = 8'hd4;
    localparam logic [7:0] CMD_AUX_TEST = 8'ha9;
    localparam logic [7:0] CMD_AUX_DIS  = 8'ha7;
    localparam logic [7:0] CMD_AUX_EN   = 8'ha8;
    localparam logic [7:0] CMD_NONE     = 8'h00;

    localparam logic [7:0] MS_SCALE11  = 8'he6;
    localparam logic [7:0] MS_STATUS   = 8'he9;
    localparam logic [7:0] MS_GET_ID   = 8'hf2;
    localparam logic [7:0] MS_ENABLE   = 8'hf4;
    localparam logic [7:0] MS_DISABLE  = 8'hf5;
    localparam logic [7:0] MS_RESET    = 8'hff;

    // Bit 8 marks an E0-prefixed key; zero means unmapped.
    function automatic logic [8:0] translate(input logic [15:0] k_in);
        logic [15:0] k;
        logic [8:0]  c;
        k = k_in;
        if (k >= 16'h41 && k <= 16'h5a) k = k + 16'h20;
        c = 9'h000;
        unique case (k)
            16'h61: c = 9'h01c; 16'h62: c = 9'h032; 16'h63: c = 9'h021;
            16'h64: c = 9'h023; 16'h65: c = 9'h024; 16'h66: c = 9'h02b;
            16'h67: c = 9'h034; 16'h68: c = 9'h033; 16'h69: c = 9'h043;
            16'h6a: c = 9'h03b; 16'h6b: c = 9'h042; 16'h6c: c = 9'h04b;
            16'h6d: c = 9'h03a; 16'h6e: c = 9'h031; 16'h6f: c = 9'h044;
            16'h70: c = 9'h04d; 16'h71: c = 9'h015; 16'h72: c = 9'h02d;
            16'h73: c = 9'h01b; 16'h74: c = 9'h02c; 16'h75: c = 9'h03c;
            16'h76: c = 9'h02a; 16'h77: c = 9'h01d; 16'h78: c = 9'h022;
            16'h79: c = 9'h035; 16'h7a: c = 9'h01a;
            16'h30: c = 9'h045; 16'h31: c = 9'h016; 16'h32: c = 9'h01e;
            16'h33: c = 9'h026; 16'h34: c = 9'h025; 16'h35: c = 9'h02e;
            16'h36: c = 9'h036; 16'h37: c = 9'h03d; 16'h38: c = 9'h03e;
            16'h39: c = 9'h046;
            16'hff08: c = 9'h066; 16'hff09: c = 9'h00d;
            16'hff0d: c = 9'h05a; 16'hff1b: c = 9'h076;
            16'hff63: c = 9'h170; 16'hffff: c = 9'h171;
            16'hff52: c = 9'h175; 16'hff54: c = 9'h172;
            16'hff51: c = 9'h16b; 16'hff53: c = 9'h174;
            16'hff55: c = 9'h17d; 16'hff56: c = 9'h17a;
            16'hff50: c = 9'h16c; 16'hff57: c = 9'h169;
            16'hffe1: c = 9'h012; 16'hffe2: c = 9'h059;
            16'hffe4: c = 9'h114; 16'hffe3: c = 9'h014;
            16'hffea: c = 9'h111; 16'hffe9: c = 9'h011;
            16'hffe5: c = 9'h058;
            16'h60, 16'h7e: c = 9'h00e;
            16'h2d, 16'h5f: c = 9'h04e;
            16'h3d, 16'h2b: c = 9'h055;
            16'h5b, 16'h7b: c = 9'h054;
            16'h5d, 16'h7d: c = 9'h05b;
            16'h5c, 16'h7c: c = 9'h05d;
            16'h3b, 16'h3a: c = 9'h04c;
            16'h27, 16'h22: c = 9'h052;
            16'h2c, 16'h3c: c = 9'h041;
            16'h2e, 16'h3e: c = 9'h049;
            16'h2f, 16'h3f: c = 9'h04a;
            16'h20: c = 9'h029; 16'h21: c = 9'h016;
            16'h40: c = 9'h01e; 16'h23: c = 9'h026;
            16'h24: c = 9'h025; 16'h25: c = 9'h02e;
            16'h5e: c = 9'h036; 16'h26: c = 9'h03d;
            16'h2a: c = 9'h03e; 16'h28: c = 9'h046;
            16'h29: c = 9'h045;
            default: c = 9'h000;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/ps2kmc_ring.sv
module ps2kmc_ring #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [7:0]               push_byte,
    input  logic                     pop,
    input  logic                     rd_last,
    output logic [7:0]               rd_data,
    output logic                     empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] rd_addr;
    logic          do_push, do_pop;
    logic          full;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == FW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    // Empty read repeats the slot just before the read pointer.
    assign rd_addr = rd_last ? ((rd_ptr_reg == '0) ? LAST : rd_ptr_reg - 1'b1) : rd_ptr_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_byte;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: rtl/ps2kmc_decode.sv
module ps2kmc_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  ps2kmc_pkg::req_t     req,
    output ps2kmc_pkg::push_t    push_plan
);
    import ps2kmc_pkg::*;

    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  ms_stat_reg, ms_stat_next;
    logic [7:0]  ms_res_reg, ms_res_next;
    logic [7:0]  ms_rate_reg, ms_rate_next;
    logic [11:0] last_x_reg, last_x_next;
    logic [11:0] last_y_reg, last_y_next;
    logic        last_ok_reg, last_ok_next;
    logic [8:0]  code;
    logic signed [12:0] dx, dy;
    logic [7:0]  b1;
    push_t       p;

    always_comb
    begin
        mode_next    = mode_reg;
        pend_next    = pend_reg;
        ms_stat_next = ms_stat_reg;
        ms_res_next  = ms_res_reg;
        ms_rate_next = ms_rate_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        last_ok_next = last_ok_reg;
        p            = '0;
        code = translate(req.key_sym);
        dx = $signed({1'b0, req.pos_x}) - $signed({1'b0, last_x_reg});
        dy = $signed({1'b0, last_y_reg}) - $signed({1'b0, req.pos_y});
        b1 = {5'b00001, req.buttons};
        if (dy > 13'sd255 || dy < -13'sd256) b1[7] = 1'b1;
        if (dx > 13'sd255 || dx < -13'sd256) b1[6] = 1'b1;
        if (dy < 0) b1[5] = 1'b1;
        if (dx < 0) b1[4] = 1'b1;
        priority case (req.op)
            OP_WR_CMD:
            begin
                priority case (req.data_byte)
                    CMD_RD_MODE:
                    begin
                        p.count = 3'd1;
                        p.b0    = mode_reg;
                    end
                    CMD_WR_MODE, CMD_AUX_LOOP, CMD_AUX_SEND: pend_next = req.data_byte;
                    CMD_AUX_TEST:
                    begin
                        p.to_aux = 1'b1;
                        p.count  = 3'd1;
                        p.b0     = 8'h00;
                    end
                    CMD_AUX_DIS: mode_next = mode_reg | MODE_AUX_OFF;
                    CMD_AUX_EN:  mode_next = mode_reg & ~MODE_AUX_OFF;
                    default: ;
                endcase
            end
            OP_WR_DATA:
            begin
                pend_next = CMD_NONE;
                priority case (pend_reg)
                    CMD_WR_MODE: mode_next = req.data_byte;
                    CMD_AUX_LOOP:
                    begin
                        p.to_aux = 1'b1;
                        p.count  = 3'd2;
                        p.b0     = req.data_byte;
                        p.b1     = ACK_BYTE;
                    end
                    CMD_AUX_SEND:
                    begin
                        p.to_aux = 1'b1;
                        p.count  = 3'd1;
                        p.b0     = ACK_BYTE;
                        priority case (req.data_byte)
                            MS_SCALE11: ms_stat_next = ms_stat_reg & ~MS_SCALING;
                            MS_STATUS:
                            begin
                                p.count = 3'd4;
                                p.b1    = ms_stat_reg;
                                p.b2    = ms_res_reg;
                                p.b3    = ms_rate_reg;
                            end
                            MS_GET_ID:
                            begin
                                p.count = 3'd2;
                                p.b1    = 8'h00;
                            end
                            MS_ENABLE:  ms_stat_next = ms_stat_reg | MS_REPORT;
                            MS_DISABLE: ms_stat_next = ms_stat_reg & ~MS_REPORT;
                            MS_RESET:
                            begin
                                ms_stat_next = 8'h00;
                                ms_res_next  = MS_DEF_RES;
                                ms_rate_next = MS_DEF_RATE;
                            end
                            default: ;
                        endcase
                    end
                    CMD_NONE:
                    begin
                        p.count = 3'd3;
                        p.b0    = ACK_BYTE;
                        p.b1    = BAT_OK;
                        p.b2    = KBD_ID;
                    end
                    default: ;
                endcase
            end
            OP_KEY:
            begin
                if (code != 9'h000)
                begin
                    // Build prefix bytes front to back.
                    if (code[8] && !req.key_down)
                    begin
                        p.count = 3'd3;
                        p.b0 = EXT_PREFIX;
                        p.b1 = BRK_PREFIX;
                        p.b2 = code[7:0];
                    end
                    else if (code[8])
                    begin
                        p.count = 3'd2;
                        p.b0 = EXT_PREFIX;
                        p.b1 = code[7:0];
                    end
                    else if (!req.key_down)
                    begin
                        p.count = 3'd2;
                        p.b0 = BRK_PREFIX;
                        p.b1 = code[7:0];
                    end
                    else
                    begin
                        p.count = 3'd1;
                        p.b0 = code[7:0];
                    end
                end
            end
            OP_POINTER:
            begin
                if (last_ok_reg)
                begin
                    p.to_aux = 1'b1;
                    p.count  = 3'd3;
                    p.b0     = b1;
                    p.b1     = dx[7:0];
                    p.b2     = dy[7:0];
                end
                last_x_next  = req.pos_x;
                last_y_next  = req.pos_y;
                last_ok_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            pend_reg    <= CMD_NONE;
            ms_stat_reg <= 8'h00;
            ms_res_reg  <= MS_DEF_RES;
            ms_rate_reg <= MS_DEF_RATE;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            last_ok_reg <= 1'b0;
            push_plan   <= '0;
        end
        else if (take)
        begin
            mode_reg    <= mode_next;
            pend_reg    <= pend_next;
            ms_stat_reg <= ms_stat_next;
            ms_res_reg  <= ms_res_next;
            ms_rate_reg <= ms_rate_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            last_ok_reg <= last_ok_next;
            push_plan   <= p;
        end
    end
endmodule

// File: rtl/ps2_keyboard_mouse_controller_top.sv
// 8042-style keyboard and mouse controller.
// Requests enter on req when start is high and busy is low. Each request
// produces exactly one result on rsp, flagged by done for one cycle; the
// receiver takes it unconditionally and cannot stall the block.
// All requests but a data read: the accept cycle decodes, then ST_PUSH pushes
// each queued byte in turn and closes the push, then ST_DONE holds the result.
// Data read: the accept cycle, then ST_READ reads the ring memory, then
// ST_DONE holds the result.
// busy drops in the cycle after done. The single write port of each ring
// memory is why a request pushes its bytes one at a time.
// Bytes pushed into a full ring are dropped.
// Reset clears pointers, fill counts and controller/mouse settings; ring
// contents stay undefined until written. No clearing pass is needed.
// irq_kbd is set while the keyboard ring holds data, irq_aux while only
// the mouse ring does; status bit 0 is set for either ring, bit 5 as irq_aux.
module ps2_keyboard_mouse_controller_top #(
    parameter int RING_DEPTH = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ps2kmc_pkg::req_t   req,
    output logic               done,
    output ps2kmc_pkg::rsp_t   rsp
);
    import ps2kmc_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] op_reg;
    logic       take;
    push_t      plan;
    logic [7:0] cur_byte;
    logic       kbd_push, aux_push, kbd_pop, aux_pop, rd_last;
    logic [7:0] kbd_q, aux_q;
    logic       kbd_empty, aux_empty;
    logic       src_kbd_reg, src_kbd_next;
    logic [7:0] status;
    logic [7:0] rv;

    assign take = start && (state_reg == ST_IDLE);
    assign busy = (state_reg != ST_IDLE);

    ps2kmc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req       (req),
        .push_plan (plan)
    );

    always_comb
    begin
        unique case (idx_reg[1:0])
            2'd0:    cur_byte = plan.b0;
            2'd1:    cur_byte = plan.b1;
            2'd2:    cur_byte = plan.b2;
            default: cur_byte = plan.b3;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        src_kbd_next = src_kbd_reg;
        kbd_push = 1'b0;
        aux_push = 1'b0;
        kbd_pop  = 1'b0;
        aux_pop  = 1'b0;
        rd_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = 3'd0;
                if (take)
                begin
                    state_next = (req.op == OP_RD_DATA) ? ST_READ : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (idx_reg < plan.count)
                begin
                    kbd_push = !plan.to_aux;
                    aux_push = plan.to_aux;
                    idx_next = idx_reg + 3'd1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                // Pop keyboard first, then aux; else repeat last keyboard byte.
                src_kbd_next = !kbd_empty || aux_empty;
                kbd_pop = !kbd_empty;
                aux_pop = kbd_empty;
                rd_last = kbd_empty && aux_empty;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ps2kmc_ring #(.DEPTH(RING_DEPTH)) u_kbd (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (kbd_push),
        .push_byte (cur_byte),
        .pop       (kbd_pop),
        .rd_last   (rd_last),
        .rd_data   (kbd_q),
        .empty     (kbd_empty)
    );

    ps2kmc_ring #(.DEPTH(RING_DEPTH)) u_aux (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (aux_push),
        .push_byte (cur_byte),
        .pop       (aux_pop),
        .rd_last   (1'b0),
        .rd_data   (aux_q),
        .empty     (aux_empty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            src_kbd_reg <= 1'b1;
            op_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            src_kbd_reg <= src_kbd_next;
            if (take)
            begin
                op_reg <= req.op;
            end
        end
    end

    always_comb
    begin
        status = STAT_BASE;
        if (!kbd_empty)
        begin
            status = status | 8'h01;
        end
        else if (!aux_empty)
        begin
            status = status | 8'h21;
        end
        unique case (op_reg)
            OP_RD_STATUS: rv = status;
            OP_RD_DATA:   rv = src_kbd_reg ? kbd_q : aux_q;
            default:      rv = 8'h00;
        endcase
    end

    assign done           = (state_reg == ST_DONE);
    assign rsp.read_value = rv;
    assign rsp.irq_kbd    = !kbd_empty;
    assign rsp.irq_aux    = kbd_empty && !aux_empty;
endmodule

// File: bench/ps2kmc_checker.sv
`timescale 1ns / 1ps

module ps2kmc_checker
    import ps2kmc_pkg::*;
#(
    parameter int RING_DEPTH = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  rsp_t rsp,
    output int   errors,
    output int   outstanding,
    output logic read_safe
);

    localparam logic [7:0] STAT_OBF     = 8'h01;
    localparam logic [7:0] STAT_AUX_OBF = 8'h20;
    localparam logic [7:0] PKT_SYNC     = 8'h08;

    localparam logic [7:0] LETTER_CODE [26] = '{
        8'h1c, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2b, 8'h34, 8'h33, 8'h43, 8'h3b,
        8'h42, 8'h4b, 8'h3a, 8'h31, 8'h44, 8'h4d, 8'h15, 8'h2d, 8'h1b, 8'h2c,
        8'h3c, 8'h2a, 8'h1d, 8'h22, 8'h35, 8'h1a
    };
    localparam logic [7:0] DIGIT_CODE [10] = '{
        8'h45, 8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36, 8'h3d, 8'h3e, 8'h46
    };

    logic [7:0] kbd_mem [RING_DEPTH];
    logic       kbd_seen [RING_DEPTH];
    logic [7:0] aux_mem [RING_DEPTH];
    int         kbd_head, kbd_tail, kbd_count;
    int         aux_head, aux_tail, aux_count;
    logic [7:0] ms_flags, ms_res, ms_rate, mode_reg, pend_cmd;
    logic [11:0] ptr_x, ptr_y;
    logic        ptr_known;
    rsp_t        rsp_queue [$];

    assign outstanding = rsp_queue.size();
    assign read_safe   = (kbd_count != 0) || (aux_count != 0) ||
                         kbd_seen[(kbd_head == 0) ? RING_DEPTH - 1 : kbd_head - 1];

    function automatic int wrap_inc(int p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    function void kbd_push(logic [7:0] b);
        if (kbd_count >= RING_DEPTH)
            return;
        kbd_mem[kbd_tail] = b;
        kbd_seen[kbd_tail] = 1'b1;
        kbd_tail = wrap_inc(kbd_tail);
        kbd_count++;
    endfunction

    function void aux_push(logic [7:0] b);
        if (aux_count >= RING_DEPTH)
            return;
        aux_mem[aux_tail] = b;
        aux_tail = wrap_inc(aux_tail);
        aux_count++;
    endfunction

    // Bit 8 flags an E0 key; zero means no scancode.
    function automatic logic [8:0] scancode(logic [15:0] sym);
        logic [15:0] k;
        k = sym;
        if (k >= 16'h41 && k <= 16'h5a)
            k = k + 16'h20;
        if (k >= 16'h61 && k <= 16'h7a)
            return {1'b0, LETTER_CODE[k - 16'h61]};
        if (k >= 16'h30 && k <= 16'h39)
            return {1'b0, DIGIT_CODE[k - 16'h30]};
        case (k)
            16'hff08: return 9'h066;
            16'hff09: return 9'h00d;
            16'hff0d: return 9'h05a;
            16'hff1b: return 9'h076;
            16'hff63: return 9'h170;
            16'hffff: return 9'h171;
            16'hff52: return 9'h175;
            16'hff54: return 9'h172;
            16'hff51: return 9'h16b;
            16'hff53: return 9'h174;
            16'hff55: return 9'h17d;
            16'hff56: return 9'h17a;
            16'hff50: return 9'h16c;
            16'hff57: return 9'h169;
            16'hffe1: return 9'h012;
            16'hffe2: return 9'h059;
            16'hffe4: return 9'h114;
            16'hffe3: return 9'h014;
            16'hffea: return 9'h111;
            16'hffe9: return 9'h011;
            16'hffe5: return 9'h058;
            16'h60, 16'h7e: return 9'h00e;
            16'h2d, 16'h5f: return 9'h04e;
            16'h3d, 16'h2b: return 9'h055;
            16'h5b, 16'h7b: return 9'h054;
            16'h5d, 16'h7d: return 9'h05b;
            16'h5c, 16'h7c: return 9'h05d;
            16'h3b, 16'h3a: return 9'h04c;
            16'h27, 16'h22: return 9'h052;
            16'h2c, 16'h3c: return 9'h041;
            16'h2e, 16'h3e: return 9'h049;
            16'h2f, 16'h3f: return 9'h04a;
            16'h20: return 9'h029;
            16'h21: return 9'h016;
            16'h40: return 9'h01e;
            16'h23: return 9'h026;
            16'h24: return 9'h025;
            16'h25: return 9'h02e;
            16'h5e: return 9'h036;
            16'h26: return 9'h03d;
            16'h2a: return 9'h03e;
            16'h28: return 9'h046;
            16'h29: return 9'h045;
            default: return 9'h000;
        endcase
    endfunction

    function void mouse_cmd(logic [7:0] v);
        aux_push(ACK_BYTE);
        case (v)
            MS_SCALE11: ms_flags &= ~MS_SCALING;
            MS_STATUS:
            begin
                aux_push(ms_flags);
                aux_push(ms_res);
                aux_push(ms_rate);
            end
            MS_GET_ID:  aux_push(8'h00);
            MS_ENABLE:  ms_flags |= MS_REPORT;
            MS_DISABLE: ms_flags &= ~MS_REPORT;
            MS_RESET:
            begin
                ms_flags = 8'h00;
                ms_res   = MS_DEF_RES;
                ms_rate  = MS_DEF_RATE;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] data_pop();
        logic [7:0] v;
        if (kbd_count != 0) begin
            v = kbd_mem[kbd_head];
            kbd_head = wrap_inc(kbd_head);
            kbd_count--;
        end else if (aux_count != 0) begin
            v = aux_mem[aux_head];
            aux_head = wrap_inc(aux_head);
            aux_count--;
        end else begin
            // Empty ring: repeat the keyboard byte just behind the read pointer.
            v = kbd_mem[(kbd_head == 0) ? RING_DEPTH - 1 : kbd_head - 1];
        end
        return v;
    endfunction

    function automatic rsp_t controller_step(req_t r);
        rsp_t       e;
        logic [8:0] code;
        logic [7:0] hdr;
        int         dx, dy;
        e = '0;
        case (r.op)
            OP_RD_STATUS:
            begin
                e.read_value = STAT_BASE;
                if (kbd_count != 0)
                    e.read_value |= STAT_OBF;
                else if (aux_count != 0)
                    e.read_value |= STAT_OBF | STAT_AUX_OBF;
            end
            OP_RD_DATA: e.read_value = data_pop();
            OP_WR_CMD:
            begin
                case (r.data_byte)
                    CMD_RD_MODE: kbd_push(mode_reg);
                    CMD_WR_MODE, CMD_AUX_LOOP, CMD_AUX_SEND: pend_cmd = r.data_byte;
                    CMD_AUX_TEST: aux_push(8'h00);
                    CMD_AUX_DIS: mode_reg |= MODE_AUX_OFF;
                    CMD_AUX_EN: mode_reg &= ~MODE_AUX_OFF;
                    default: ;
                endcase
            end
            OP_WR_DATA:
            begin
                case (pend_cmd)
                    CMD_WR_MODE: mode_reg = r.data_byte;
                    CMD_AUX_LOOP:
                    begin
                        aux_push(r.data_byte);
                        aux_push(ACK_BYTE);
                    end
                    CMD_AUX_SEND: mouse_cmd(r.data_byte);
                    CMD_NONE:
                    begin
                        kbd_push(ACK_BYTE);
                        kbd_push(BAT_OK);
                        kbd_push(KBD_ID);
                    end
                    default: ;
                endcase
                pend_cmd = CMD_NONE;
            end
            OP_KEY:
            begin
                code = scancode(r.key_sym);
                if (code != 9'h000) begin
                    if (code[8])
                        kbd_push(EXT_PREFIX);
                    if (!r.key_down)
                        kbd_push(BRK_PREFIX);
                    kbd_push(code[7:0]);
                end
            end
            OP_POINTER:
            begin
                if (ptr_known) begin
                    dx = int'(r.pos_x) - int'(ptr_x);
                    dy = int'(ptr_y) - int'(r.pos_y);
                    hdr = PKT_SYNC | {5'b0, r.buttons};
                    if (dy > 255 || dy < -256)
                        hdr |= 8'h80;
                    if (dx > 255 || dx < -256)
                        hdr |= 8'h40;
                    if (dy < 0)
                        hdr |= 8'h20;
                    if (dx < 0)
                        hdr |= 8'h10;
                    aux_push(hdr);
                    aux_push(dx[7:0]);
                    aux_push(dy[7:0]);
                end
                ptr_x = r.pos_x;
                ptr_y = r.pos_y;
                ptr_known = 1'b1;
            end
            default: ;
        endcase
        e.irq_kbd = (kbd_count != 0);
        e.irq_aux = (kbd_count == 0) && (aux_count != 0);
        return e;
    endfunction

    task automatic report(string field, logic [7:0] got, logic [7:0] want);
        $display("%0t: mismatch on %s: got %02h, expected %02h", $time, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++)
                kbd_seen[i] = 1'b0;
            kbd_head = 0; kbd_tail = 0; kbd_count = 0;
            aux_head = 0; aux_tail = 0; aux_count = 0;
            ms_flags = 8'h00;
            ms_res   = MS_DEF_RES;
            ms_rate  = MS_DEF_RATE;
            mode_reg = MODE_RESET;
            pend_cmd = CMD_NONE;
            ptr_x = '0; ptr_y = '0; ptr_known = 1'b0;
            errors = 0;
            rsp_queue.delete();
        end else begin
            rsp_t want;
            if (start && !busy)
                rsp_queue.push_back(controller_step(req));
            if (done) begin
                if (rsp_queue.size() == 0) begin
                    $display("%0t: result with no request waiting", $time);
                    errors++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (rsp.read_value !== want.read_value)
                        report("read_value", rsp.read_value, want.read_value);
                    if (rsp.irq_kbd !== want.irq_kbd)
                        report("irq_kbd", 8'(rsp.irq_kbd), 8'(want.irq_kbd));
                    if (rsp.irq_aux !== want.irq_aux)
                        report("irq_aux", 8'(rsp.irq_aux), 8'(want.irq_aux));
                end
            end
        end
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ps2kmc_pkg::*;

    localparam int RANDOM_REQUESTS = 1450;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int REQ_W           = $bits(req_t);
    localparam logic [2:0] OP_RSVD_LO = 3'd6;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    localparam logic [15:0] SPECIAL_SYMS [54] = '{
        16'hff08, 16'hff09, 16'hff0d, 16'hff1b, 16'hff63, 16'hffff, 16'hff52,
        16'hff54, 16'hff51, 16'hff53, 16'hff55, 16'hff56, 16'hff50, 16'hff57,
        16'hffe1, 16'hffe2, 16'hffe4, 16'hffe3, 16'hffea, 16'hffe9, 16'hffe5,
        16'h60, 16'h7e, 16'h2d, 16'h5f, 16'h3d, 16'h2b, 16'h5b, 16'h7b, 16'h5d,
        16'h7d, 16'h5c, 16'h7c, 16'h3b, 16'h3a, 16'h27, 16'h22, 16'h2c, 16'h3c,
        16'h2e, 16'h3e, 16'h2f, 16'h3f, 16'h20, 16'h21, 16'h40, 16'h23, 16'h24,
        16'h25, 16'h5e, 16'h26, 16'h2a, 16'h28, 16'h29
    };
    localparam logic [7:0] CMD_POOL [7] = '{
        CMD_RD_MODE, CMD_WR_MODE, CMD_AUX_LOOP, CMD_AUX_SEND,
        CMD_AUX_TEST, CMD_AUX_DIS, CMD_AUX_EN
    };
    localparam logic [7:0] MOUSE_POOL [6] = '{
        MS_SCALE11, MS_STATUS, MS_GET_ID, MS_ENABLE, MS_DISABLE, MS_RESET
    };

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy, done, read_safe;
    rsp_t rsp;
    int   errors, outstanding;
    int   cycles = 0;
    int   issued = 0;
    logic no_gaps = 1'b0;
    int   read_weight = 20;
    logic [11:0] cur_x = '0, cur_y = '0;

    ps2_keyboard_mouse_controller_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .rsp(rsp)
    );

    ps2kmc_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .errors(errors), .outstanding(outstanding),
        .read_safe(read_safe)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic req_t noise_req(logic [2:0] op);
        req_t r;
        r = REQ_W'({$urandom, $urandom});
        r.op = op;
        return r;
    endfunction

    // Hold start across back-to-back requests; drop it only for a gap.
    task automatic issue(input req_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        // Never read back a keyboard slot that was never filled.
        if (r.op == OP_RD_DATA && !read_safe)
            r.op = OP_RD_STATUS;
        start <= 1'b1;
        req <= r;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        issued++;
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] db);
        req_t r;
        r = noise_req(op);
        r.data_byte = db;
        issue(r);
    endtask

    task automatic send_key(logic [15:0] sym, logic down);
        req_t r;
        r = noise_req(OP_KEY);
        r.key_sym = sym;
        r.key_down = down;
        issue(r);
    endtask

    task automatic send_ptr(logic [2:0] btn, logic [11:0] x, logic [11:0] y);
        req_t r;
        r = noise_req(OP_POINTER);
        r.buttons = btn;
        r.pos_x = x;
        r.pos_y = y;
        cur_x = x;
        cur_y = y;
        issue(r);
    endtask

    task automatic random_request();
        int pick;
        logic [7:0] cmd;
        logic [15:0] sym;
        pick = $urandom_range(0, 99);
        if (pick < read_weight) begin
            send_op(OP_RD_DATA, 8'($urandom));
        end else if (pick < read_weight + 22) begin
            // a command, mostly from CMD_POOL, followed by a data byte
            cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                              : CMD_POOL[$urandom_range(0, 6)];
            send_op(OP_WR_CMD, cmd);
            if (cmd == CMD_AUX_SEND && $urandom_range(0, 5) != 0)
                send_op(OP_WR_DATA, MOUSE_POOL[$urandom_range(0, 5)]);
            else
                send_op(OP_WR_DATA, 8'($urandom));
        end else if (pick < read_weight + 30) begin
            send_op(OP_WR_DATA, 8'($urandom));
        end else if (pick < read_weight + 52) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: sym = 16'(16'h41 + $urandom_range(0, 25)
                                      + 16'h20 * $urandom_range(0, 1));
                4, 5:       sym = 16'(16'h30 + $urandom_range(0, 9));
                6, 7, 8:    sym = SPECIAL_SYMS[$urandom_range(0, 53)];
                default:    sym = 16'($urandom);
            endcase
            send_key(sym, 1'($urandom));
        end else if (pick < read_weight + 68) begin
            if ($urandom_range(0, 3) == 0)
                send_ptr(3'($urandom), 12'($urandom), 12'($urandom));
            else
                send_ptr(3'($urandom), cur_x + 12'($urandom_range(0, 600) - 300),
                         cur_y + 12'($urandom_range(0, 600) - 300));
        end else if (pick < read_weight + 76) begin
            send_op(OP_RD_STATUS, 8'($urandom));
        end else if (pick < read_weight + 78) begin
            send_op($urandom_range(0, 1) ? OP_RSVD_LO : OP_RSVD_HI, 8'($urandom));
        end else begin
            send_op(OP_WR_CMD, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_op(OP_RD_STATUS, 8'h00);
        send_op(OP_WR_DATA, 8'hff);
        repeat (4) send_op(OP_RD_DATA, 8'h00);
        send_op(OP_WR_CMD, CMD_RD_MODE);
        send_op(OP_WR_CMD, CMD_WR_MODE);
        send_op(OP_WR_DATA, 8'hff);
        send_op(OP_WR_CMD, CMD_RD_MODE);
        send_op(OP_WR_CMD, CMD_AUX_DIS);
        send_op(OP_WR_CMD, CMD_AUX_EN);
        send_op(OP_WR_CMD, CMD_AUX_TEST);
        send_op(OP_WR_CMD, 8'h12);
        send_op(OP_WR_CMD, CMD_AUX_LOOP);
        send_op(OP_WR_DATA, 8'h00);
        foreach (MOUSE_POOL[i]) begin
            send_op(OP_WR_CMD, CMD_AUX_SEND);
            send_op(OP_WR_DATA, MOUSE_POOL[i]);
        end
        send_op(OP_WR_CMD, CMD_AUX_SEND);
        send_op(OP_WR_DATA, 8'hf3);
        send_key(16'h0041, 1'b1);
        send_key(16'hff63, 1'b0);
        send_key(16'hffe4, 1'b1);
        send_key(16'hffff, 1'b0);
        send_key(16'h0000, 1'b1);
        send_ptr(3'd0, 12'd0, 12'd0);
        send_ptr(3'd7, 12'hfff, 12'hfff);
        send_ptr(3'd5, 12'd0, 12'd0);
        send_op(OP_RSVD_LO, 8'h00);
        send_op(OP_RSVD_HI, 8'hff);
        send_op(OP_RD_STATUS, 8'h00);
        repeat (40) send_op(OP_RD_DATA, 8'h00);

        // every 150 requests, pick a low or high read weight at random to fill or drain the rings
        for (int i = 0; i < RANDOM_REQUESTS;) begin
            if (i % 150 == 0) begin
                read_weight = $urandom_range(0, 1) ? 4 : 45;
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            random_request();
            i = issued - 70;
            if (i < 0)
                i = 0;
        end

        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/ps2kmc_pkg.sv
rtl/ps2kmc_ring.sv
rtl/ps2kmc_decode.sv
rtl/ps2_keyboard_mouse_controller_top.sv
bench/ps2kmc_checker.sv
bench/testbench.sv
